// ===== rtl/stmh_pkg.sv =====
// stmh_pkg: shared types and constants of the sphere/triangle-mesh hit core
// used by stmh_mac, stmh_div and sphere_triangle_mesh_hit_core; no dependencies
`default_nettype none

package stmh_pkg;

    localparam int CW    = 16;      // coordinate width, signed Q8.8
    localparam int DW    = 36;      // dot product width
    localparam int XW    = 72;      // accumulator and cross term width
    localparam int SPLIT = 20;      // low slice of a wide factor
    localparam int AW    = DW + 1;  // multiplier operand a
    localparam int BW    = SPLIT + 1; // multiplier operand b
    localparam int NW    = 20;      // closest point width before saturation
    localparam int QW    = 16;      // ratio width, unsigned Q0.16
    localparam int IW    = 16;      // triangle index width
    localparam int RW    = 3;       // register index width

    localparam logic [RW-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [RW-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [RW-1:0] CFG_CENTER_Z = 3'd2;
    localparam logic [RW-1:0] CFG_RADIUS   = 3'd3;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t vert_a_x;
        coord_t vert_a_y;
        coord_t vert_a_z;
        coord_t vert_b_x;
        coord_t vert_b_y;
        coord_t vert_b_z;
        coord_t vert_c_x;
        coord_t vert_c_y;
        coord_t vert_c_z;
        logic   last_triangle;
    } tri_in_t;

    typedef struct packed {
        logic            hit;
        coord_t          near_x;
        coord_t          near_y;
        coord_t          near_z;
        logic [IW-1:0]   hit_index;
    } hit_out_t;

    typedef struct packed {
        logic en;
        logic clr;
        logic sub;
        logic shift;
    } mac_op_t;

endpackage

`default_nettype wire

// ===== rtl/stmh_mac.sv =====
// stmh_mac: shared multiply-accumulate unit, one product per cycle
// depends on stmh_pkg
`default_nettype none

module stmh_mac import stmh_pkg::*; (
    input  logic                 aclk,
    input  mac_op_t              op,
    input  logic signed [AW-1:0] mul_a,
    input  logic signed [BW-1:0] mul_b,
    output logic signed [XW-1:0] acc
);

    logic signed [AW+BW-1:0] prod;
    logic signed [XW-1:0]    term;
    logic signed [XW-1:0]    base;
    logic signed [XW-1:0]    acc_reg;
    logic signed [XW-1:0]    acc_next;

    assign prod = mul_a * mul_b;
    // upper slice of a split factor weighs 2^SPLIT
    assign term = op.shift ? (XW'(prod) <<< SPLIT) : XW'(prod);
    assign base = op.clr ? '0 : acc_reg;

    always_comb begin
        acc_next = acc_reg;
        if (op.en) begin
            acc_next = op.sub ? (base - term) : (base + term);
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// ===== rtl/stmh_div.sv =====
// stmh_div: restoring divider for the unsigned Q0.16 edge and face ratios
// depends on stmh_pkg
`default_nettype none

module stmh_div import stmh_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [XW-1:0] num,
    input  logic signed [XW-1:0] den,
    output logic                 done,
    output logic [QW-1:0]        quot
);

    typedef enum logic [2:0] {
        DV_IDLE  = 3'b001,
        DV_CHECK = 3'b010,
        DV_ITER  = 3'b100
    } dv_state_t;

    dv_state_t           state_reg, state_next;
    logic [XW:0]         rem_reg, rem_next;
    logic [XW:0]         dvs_reg, dvs_next;
    logic [QW-1:0]       q_reg, q_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [XW-1:0]       num_abs, den_abs;
    logic [XW:0]         shifted;
    logic                trivial;

    assign num_abs = num[XW-1] ? (~num + 1'b1) : num;
    assign den_abs = den[XW-1] ? (~den + 1'b1) : den;
    assign trivial = (num == '0) || (den == '0) || (num[XW-1] != den[XW-1]);
    assign shifted = {rem_reg[XW-1:0], 1'b0};

    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            DV_IDLE: begin
                if (start) begin
                    if (trivial) begin
                        q_next    = '0;
                        done_next = 1'b1;
                    end else begin
                        rem_next   = {1'b0, num_abs};
                        dvs_next   = {1'b0, den_abs};
                        state_next = DV_CHECK;
                    end
                end
            end
            DV_CHECK: begin
                // quotient of one or more saturates
                if (dvs_reg <= rem_reg) begin
                    q_next     = '1;
                    done_next  = 1'b1;
                    state_next = DV_IDLE;
                end else begin
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = DV_ITER;
                end
            end
            DV_ITER: begin
                if (dvs_reg <= shifted) begin
                    rem_next = shifted - dvs_reg;
                    q_next   = {q_reg[QW-2:0], 1'b1};
                end else begin
                    rem_next = shifted;
                    q_next   = {q_reg[QW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(QW - 1)) begin
                    done_next  = 1'b1;
                    state_next = DV_IDLE;
                end
            end
            default: begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

// ===== rtl/sphere_triangle_mesh_hit_core.sv =====
// sphere_triangle_mesh_hit_core: closest point of each triangle to a sphere center,
// first hit of a mesh reported on its last triangle; uses stmh_pkg, stmh_mac, stmh_div
//
//   channel  | ports                                | word
//   ---------+--------------------------------------+-------------------------------
//   input    | s_valid, s_ready, s_data             | tri_in_t: three vertices, last
//   result   | m_valid, m_ready, m_data             | hit_out_t: hit, point, index
//   config   | cfg_wr_en, cfg_index, cfg_wr_data    | center x/y/z, radius
//
// one triangle keeps the core busy least when nearest to the first vertex and most in the
// face region with both ratios iterating, and the core returns to idle to take the next;
// the time is set by the single shared multiplier, one product per cycle, and the 16-step
// ratio divider, which runs twice for a face point
// s_ready is high only while idle; a result waits in the output register while the
// next triangle is taken; a last triangle holds at its end while a result is unread
// reset is synchronous, active low, and clears config and the mesh state
`default_nettype none

module sphere_triangle_mesh_hit_core import stmh_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  tri_in_t         s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output hit_out_t        m_data,
    input  logic            cfg_wr_en,
    input  logic [RW-1:0]   cfg_index,
    input  logic [CW-1:0]   cfg_wr_data
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_DOT   = 8'b00000010,
        ST_CROSS = 8'b00000100,
        ST_DEN   = 8'b00001000,
        ST_DIV   = 8'b00010000,
        ST_POINT = 8'b00100000,
        ST_DIST  = 8'b01000000,
        ST_FIN   = 8'b10000000
    } state_t;

    typedef enum logic [1:0] {
        PM_AB,
        PM_AC,
        PM_BC,
        PM_FACE
    } pmode_t;

    function automatic coord_t pick3(coord_t x, coord_t y, coord_t z, logic [1:0] i);
        coord_t r;
        unique case (i)
            2'd1:    r = y;
            2'd2:    r = z;
            default: r = x;
        endcase
        return r;
    endfunction

    function automatic coord_t sat_coord(logic signed [NW-1:0] v);
        coord_t r;
        if (v > NW'(32'sd32767)) begin
            r = 16'sh7fff;
        end else if (v < -NW'(32'sd32768)) begin
            r = 16'sh8000;
        end else begin
            r = CW'(v);
        end
        return r;
    endfunction

    state_t                 state_reg, state_next;
    logic [2:0]             step_reg, step_next;
    logic [2:0]             sel_reg, sel_next;
    logic [1:0]             k_reg, k_next;
    logic                   ridx_reg, ridx_next;
    pmode_t                 pmode_reg, pmode_next;
    tri_in_t                tri_reg, tri_next;
    logic signed [DW-1:0]   d_reg [6];
    logic signed [DW-1:0]   d_next [6];
    logic signed [XW-1:0]   vc_reg, vc_next, vb_reg, vb_next, va_reg, va_next;
    logic signed [XW-1:0]   num_reg, num_next, den_reg, den_next;
    logic [QW-1:0]          rv_reg, rv_next, rw_reg, rw_next;
    logic signed [NW-1:0]   near_reg [3];
    logic signed [NW-1:0]   near_next [3];

    coord_t                 ctr_x_reg, ctr_y_reg, ctr_z_reg;
    logic [CW-1:0]          radius_reg;

    logic                   found_reg, found_next;
    coord_t                 kept_reg [3];
    coord_t                 kept_next [3];
    logic [IW-1:0]          kept_idx_reg, kept_idx_next;
    logic [IW-1:0]          tri_cnt_reg, tri_cnt_next;
    logic                   m_valid_reg, m_valid_next;
    hit_out_t               m_data_reg, m_data_next;

    logic [1:0]             comp;
    coord_t                 a_k, b_k, c_k, ctr_k;
    logic signed [CW:0]     ab_k, ac_k, bc_k, ap_k, bp_k, cp_k;
    logic signed [CW:0]     dot_u, dot_v, edge_k, base_k;
    logic signed [NW-1:0]   near_k;
    logic signed [BW-1:0]   dv_k;
    logic signed [DW-1:0]   acc_d, cp_p, cp_q, cp_r, cp_s, fac_a, fac_b;
    logic signed [DW:0]     e43, e56;
    logic                   acc_le0;
    logic                   take;

    mac_op_t                mac_op;
    logic signed [AW-1:0]   mul_a;
    logic signed [BW-1:0]   mul_b;
    logic signed [XW-1:0]   acc;
    logic                   div_start;
    logic                   div_done;
    logic [QW-1:0]          div_q;

    stmh_mac u_mac (
        .aclk  (aclk),
        .op    (mac_op),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .acc   (acc)
    );

    stmh_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_reg),
        .den     (den_reg),
        .done    (div_done),
        .quot    (div_q)
    );

    // component selection for the per-axis steps
    always_comb begin
        unique case (state_reg)
            ST_DOT:   comp = step_reg[1:0];
            ST_DIST:  comp = step_reg[1:0] - 2'd1;
            ST_POINT: comp = k_reg;
            default:  comp = 2'd0;
        endcase
    end

    assign a_k   = pick3(tri_reg.vert_a_x, tri_reg.vert_a_y, tri_reg.vert_a_z, comp);
    assign b_k   = pick3(tri_reg.vert_b_x, tri_reg.vert_b_y, tri_reg.vert_b_z, comp);
    assign c_k   = pick3(tri_reg.vert_c_x, tri_reg.vert_c_y, tri_reg.vert_c_z, comp);
    assign ctr_k = pick3(ctr_x_reg, ctr_y_reg, ctr_z_reg, comp);

    assign ab_k = (CW+1)'(b_k) - (CW+1)'(a_k);
    assign ac_k = (CW+1)'(c_k) - (CW+1)'(a_k);
    assign bc_k = (CW+1)'(c_k) - (CW+1)'(b_k);
    assign ap_k = (CW+1)'(ctr_k) - (CW+1)'(a_k);
    assign bp_k = (CW+1)'(ctr_k) - (CW+1)'(b_k);
    assign cp_k = (CW+1)'(ctr_k) - (CW+1)'(c_k);

    assign near_k = near_reg[comp];
    assign dv_k   = BW'(near_k) - BW'(ctr_k);

    assign acc_d   = $signed(acc[DW-1:0]);
    assign acc_le0 = acc[XW-1] || (acc == '0);
    assign e43     = (DW+1)'(d_reg[3]) - (DW+1)'(d_reg[2]);
    assign e56     = (DW+1)'(d_reg[4]) - (DW+1)'(d_reg[5]);
    assign take    = !found_reg && acc_le0;

    // dot operands: even index uses ab, odd uses ac; pairs use ap, bp, cp
    assign dot_u = sel_reg[0] ? ac_k : ab_k;
    always_comb begin
        unique case (sel_reg[2:1])
            2'd0:    dot_v = ap_k;
            2'd1:    dot_v = bp_k;
            default: dot_v = cp_k;
        endcase
    end

    // cross terms p*q - r*s
    always_comb begin
        unique case (sel_reg[1:0])
            2'd0: begin
                cp_p = d_reg[0]; cp_q = d_reg[3]; cp_r = d_reg[2]; cp_s = d_reg[1];
            end
            2'd1: begin
                cp_p = d_reg[4]; cp_q = d_reg[1]; cp_r = d_reg[0]; cp_s = d_reg[5];
            end
            default: begin
                cp_p = d_reg[2]; cp_q = d_reg[5]; cp_r = d_reg[4]; cp_s = d_reg[3];
            end
        endcase
    end
    assign fac_a = step_reg[1] ? cp_r : cp_p;
    assign fac_b = step_reg[1] ? cp_s : cp_q;

    // edge direction and base point of the closest point step
    always_comb begin
        unique case (pmode_reg)
            PM_AC:   edge_k = ac_k;
            PM_BC:   edge_k = bc_k;
            PM_FACE: edge_k = (step_reg == 3'd0) ? ab_k : ac_k;
            default: edge_k = ab_k;
        endcase
        base_k = (pmode_reg == PM_BC) ? (CW+1)'(b_k) : (CW+1)'(a_k);
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        sel_next      = sel_reg;
        k_next        = k_reg;
        ridx_next     = ridx_reg;
        pmode_next    = pmode_reg;
        tri_next      = tri_reg;
        vc_next       = vc_reg;
        vb_next       = vb_reg;
        va_next       = va_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        rv_next       = rv_reg;
        rw_next       = rw_reg;
        found_next    = found_reg;
        kept_idx_next = kept_idx_reg;
        tri_cnt_next  = tri_cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        for (int i = 0; i < 6; i++) begin
            d_next[i] = d_reg[i];
        end
        for (int i = 0; i < 3; i++) begin
            near_next[i] = near_reg[i];
            kept_next[i] = kept_reg[i];
        end
        mac_op    = '0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    tri_next   = s_data;
                    sel_next   = 3'd0;
                    step_next  = 3'd0;
                    state_next = ST_DOT;
                end
            end

            ST_DOT: begin
                mul_a = AW'(dot_u);
                mul_b = BW'(dot_v);
                if (step_reg != 3'd3) begin
                    mac_op.en  = 1'b1;
                    mac_op.clr = (step_reg == 3'd0);
                    step_next  = step_reg + 3'd1;
                end else begin
                    d_next[sel_reg] = acc_d;
                    step_next       = 3'd0;
                    sel_next        = sel_reg + 3'd1;
                    if (sel_reg == 3'd1) begin
                        // vertex a region
                        if (d_reg[0] <= 0 && acc_d <= 0) begin
                            near_next[0] = NW'(tri_reg.vert_a_x);
                            near_next[1] = NW'(tri_reg.vert_a_y);
                            near_next[2] = NW'(tri_reg.vert_a_z);
                            state_next   = ST_DIST;
                        end
                    end else if (sel_reg == 3'd3) begin
                        if (d_reg[2] >= 0 && acc_d <= d_reg[2]) begin
                            near_next[0] = NW'(tri_reg.vert_b_x);
                            near_next[1] = NW'(tri_reg.vert_b_y);
                            near_next[2] = NW'(tri_reg.vert_b_z);
                            state_next   = ST_DIST;
                        end else begin
                            sel_next   = 3'd0;
                            state_next = ST_CROSS;
                        end
                    end else if (sel_reg == 3'd5) begin
                        if (acc_d >= 0 && d_reg[4] <= acc_d) begin
                            near_next[0] = NW'(tri_reg.vert_c_x);
                            near_next[1] = NW'(tri_reg.vert_c_y);
                            near_next[2] = NW'(tri_reg.vert_c_z);
                            state_next   = ST_DIST;
                        end else begin
                            sel_next   = 3'd1;
                            state_next = ST_CROSS;
                        end
                    end
                end
            end

            ST_CROSS: begin
                mul_a = AW'(fac_a);
                mul_b = step_reg[0] ? BW'($signed(fac_b[DW-1:SPLIT]))
                                    : $signed({1'b0, fac_b[SPLIT-1:0]});
                if (step_reg != 3'd4) begin
                    mac_op.en    = 1'b1;
                    mac_op.clr   = (step_reg == 3'd0);
                    mac_op.sub   = step_reg[1];
                    mac_op.shift = step_reg[0];
                    step_next    = step_reg + 3'd1;
                end else begin
                    step_next = 3'd0;
                    unique case (sel_reg[1:0])
                        2'd0: begin
                            vc_next = acc;
                            if (acc_le0 && d_reg[0] >= 0 && d_reg[2] <= 0) begin
                                num_next   = XW'(d_reg[0]);
                                den_next   = XW'(d_reg[0]) - XW'(d_reg[2]);
                                pmode_next = PM_AB;
                                state_next = ST_DIV;
                            end else begin
                                sel_next   = 3'd4;
                                state_next = ST_DOT;
                            end
                        end
                        2'd1: begin
                            vb_next = acc;
                            if (acc_le0 && d_reg[1] >= 0 && d_reg[5] <= 0) begin
                                num_next   = XW'(d_reg[1]);
                                den_next   = XW'(d_reg[1]) - XW'(d_reg[5]);
                                pmode_next = PM_AC;
                                state_next = ST_DIV;
                            end else begin
                                sel_next = 3'd2;
                            end
                        end
                        default: begin
                            va_next = acc;
                            if (acc_le0 && e43 >= 0 && e56 >= 0) begin
                                num_next   = XW'(e43);
                                den_next   = XW'(e43) + XW'(e56);
                                pmode_next = PM_BC;
                                state_next = ST_DIV;
                            end else begin
                                state_next = ST_DEN;
                            end
                        end
                    endcase
                end
            end

            ST_DEN: begin
                num_next   = vb_reg;
                den_next   = va_reg + vb_reg + vc_reg;
                pmode_next = PM_FACE;
                ridx_next  = 1'b0;
                step_next  = 3'd0;
                state_next = ST_DIV;
            end

            ST_DIV: begin
                if (step_reg == 3'd0) begin
                    div_start = 1'b1;
                    step_next = 3'd1;
                end else if (div_done) begin
                    step_next = 3'd0;
                    if (pmode_reg == PM_FACE && !ridx_reg) begin
                        // second ratio of the face point
                        rv_next   = div_q;
                        num_next  = vc_reg;
                        ridx_next = 1'b1;
                    end else begin
                        if (pmode_reg == PM_FACE) begin
                            rw_next = div_q;
                        end else begin
                            rv_next = div_q;
                        end
                        k_next     = 2'd0;
                        state_next = ST_POINT;
                    end
                end
            end

            ST_POINT: begin
                mul_a = AW'(edge_k);
                mul_b = (step_reg == 3'd0) ? $signed({5'd0, rv_reg})
                                           : $signed({5'd0, rw_reg});
                if (step_reg == 3'd0 || (step_reg == 3'd1 && pmode_reg == PM_FACE)) begin
                    mac_op.en  = 1'b1;
                    mac_op.clr = (step_reg == 3'd0);
                    step_next  = step_reg + 3'd1;
                end else begin
                    near_next[k_reg] = NW'(base_k) + $signed(acc[QW+NW-1:QW]);
                    step_next        = 3'd0;
                    if (k_reg == 2'd2) begin
                        state_next = ST_DIST;
                    end else begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end

            ST_DIST: begin
                if (step_reg == 3'd0) begin
                    // start from minus radius squared
                    mul_a      = $signed({21'd0, radius_reg});
                    mul_b      = $signed({5'd0, radius_reg});
                    mac_op.en  = 1'b1;
                    mac_op.clr = 1'b1;
                    mac_op.sub = 1'b1;
                    step_next  = 3'd1;
                end else if (step_reg != 3'd4) begin
                    mul_a     = AW'(dv_k);
                    mul_b     = dv_k;
                    mac_op.en = 1'b1;
                    step_next = step_reg + 3'd1;
                end else begin
                    step_next  = 3'd0;
                    state_next = ST_FIN;
                end
            end

            ST_FIN: begin
                // acc holds |p - c|^2 - r^2 and stays put here
                if (!(tri_reg.last_triangle && m_valid_reg && !m_ready)) begin
                    if (tri_reg.last_triangle) begin
                        m_data_next.hit       = found_reg || take;
                        m_data_next.near_x    = take ? sat_coord(near_reg[0]) : kept_reg[0];
                        m_data_next.near_y    = take ? sat_coord(near_reg[1]) : kept_reg[1];
                        m_data_next.near_z    = take ? sat_coord(near_reg[2]) : kept_reg[2];
                        m_data_next.hit_index = take ? tri_cnt_reg : kept_idx_reg;
                        m_valid_next          = 1'b1;
                        found_next            = 1'b0;
                        kept_idx_next         = '0;
                        tri_cnt_next          = '0;
                        for (int i = 0; i < 3; i++) begin
                            kept_next[i] = '0;
                        end
                    end else begin
                        if (take) begin
                            found_next    = 1'b1;
                            kept_idx_next = tri_cnt_reg;
                            for (int i = 0; i < 3; i++) begin
                                kept_next[i] = sat_coord(near_reg[i]);
                            end
                        end
                        tri_cnt_next = tri_cnt_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            sel_reg      <= '0;
            k_reg        <= '0;
            ridx_reg     <= 1'b0;
            pmode_reg    <= PM_AB;
            found_reg    <= 1'b0;
            kept_idx_reg <= '0;
            tri_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
            ctr_x_reg    <= '0;
            ctr_y_reg    <= '0;
            ctr_z_reg    <= '0;
            radius_reg   <= '0;
            for (int i = 0; i < 3; i++) begin
                kept_reg[i] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            sel_reg      <= sel_next;
            k_reg        <= k_next;
            ridx_reg     <= ridx_next;
            pmode_reg    <= pmode_next;
            found_reg    <= found_next;
            kept_idx_reg <= kept_idx_next;
            tri_cnt_reg  <= tri_cnt_next;
            m_valid_reg  <= m_valid_next;
            for (int i = 0; i < 3; i++) begin
                kept_reg[i] <= kept_next[i];
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_CENTER_X: ctr_x_reg  <= cfg_wr_data;
                    CFG_CENTER_Y: ctr_y_reg  <= cfg_wr_data;
                    CFG_CENTER_Z: ctr_z_reg  <= cfg_wr_data;
                    CFG_RADIUS:   radius_reg <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        tri_reg    <= tri_next;
        vc_reg     <= vc_next;
        vb_reg     <= vb_next;
        va_reg     <= va_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        rv_reg     <= rv_next;
        rw_reg     <= rw_next;
        m_data_reg <= m_data_next;
        for (int i = 0; i < 6; i++) begin
            d_reg[i] <= d_next[i];
        end
        for (int i = 0; i < 3; i++) begin
            near_reg[i] <= near_next[i];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
